FILE: hw/rtl/fdsu_pkg.sv
// Package: command codes, status codes and shared types of the data-stack unit.
`default_nettype none
package fdsu_pkg;
	localparam logic [4:0] CMD_PUSH = 5'd0, CMD_DUP = 5'd1, CMD_DROP = 5'd2, CMD_SWAP = 5'd3,
		CMD_OVER = 5'd4, CMD_ADD = 5'd5, CMD_SUB = 5'd6, CMD_MUL = 5'd7, CMD_DIV = 5'd8,
		CMD_MOD = 5'd9, CMD_LSHIFT = 5'd10, CMD_RSHIFT = 5'd11, CMD_AND = 5'd12,
		CMD_OR = 5'd13, CMD_XOR = 5'd14, CMD_EQ = 5'd15, CMD_NE = 5'd16, CMD_GT = 5'd17,
		CMD_GE = 5'd18, CMD_LT = 5'd19, CMD_LE = 5'd20, CMD_DEPTH = 5'd21,
		CMD_INVERT = 5'd22, CMD_NEGATE = 5'd23, CMD_PICK = 5'd24, CMD_ROLL = 5'd25,
		CMD_DOT = 5'd26;
	localparam logic [1:0] ST_OK = 2'd0, ST_UNDER = 2'd1, ST_DIVZ = 2'd2, ST_OVER = 2'd3;
	localparam logic [15:0] TRUE_CELL = 16'hFFFF;
	typedef struct packed {
		logic        start;
		logic        is_mod;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} div_req_t;
	typedef struct packed {
		logic        done;
		logic [15:0] result;
	} div_rsp_t;
endpackage
`default_nettype wire

FILE: hw/rtl/fdsu_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module fdsu_div import fdsu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [15:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic        qneg_q;
	logic        rneg_q;
	logic        mod_q;
	logic [16:0] trial;
	logic [15:0] ua;
	logic [15:0] ub;

	assign ua = req.dividend[15] ? 16'(-req.dividend) : req.dividend;
	assign ub = req.divisor[15] ? 16'(-req.divisor) : req.divisor;
	assign trial = {rem_q, quo_q[15]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= ua;
			rem_q  <= '0;
			dvs_q  <= ub;
			qneg_q <= req.dividend[15] ^ req.divisor[15];
			rneg_q <= req.dividend[15];
			mod_q  <= req.is_mod;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = mod_q ? (rneg_q ? 16'(-rem_q) : rem_q)
		: (qneg_q ? 16'(-quo_q) : quo_q);
endmodule
`default_nettype wire

FILE: hw/rtl/forth_data_stack_unit.sv
// Top level: Forth data-stack execution unit around one synchronous stack memory.
`default_nettype none
// Each transaction runs through a sequencer around one stack memory with one write port and
// one registered read port. The read of the second cell, or of the picked cell, is issued
// with the accept. The operation follows in the next cycle and, for most commands, loads the
// result register. Pick passes through a DONE state; division and modulo wait in the DIV state
// for the bit-serial divider. Roll with a count above zero moves one cell at a time, through a
// read state and a write state per cell. The top of stack is kept in a register. The stack memory
// needs no clearing after reset; the input is taken only when the result register is free.
module forth_data_stack_unit import fdsu_pkg::*; #(
	parameter int STACK_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  command,
	input  wire logic [15:0] literal,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      top_value,
	output logic [8:0]       stack_depth,
	output logic [15:0]      popped_value,
	output logic             popped_valid
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0, S_RD2 = 3'd1, S_EXEC = 3'd2, S_DIV = 3'd3,
		S_RRD = 3'd4, S_RWR = 3'd5, S_DONE = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   tos_q;
	logic [4:0]    cmd_q;
	logic [15:0]   lit_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] end_q;
	logic [15:0]   saved_q;
	logic          first_q;

	logic [15:0]   mem [STACK_DEPTH];
	logic [15:0]   rd_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [15:0]   wdata;
	logic          re;

	logic          ov_q;
	logic [1:0]    ost_q;
	logic [15:0]   otop_q;
	logic [8:0]    odep_q;
	logic [15:0]   opop_q;
	logic          opv_q;

	div_req_t dreq;
	div_rsp_t drsp;

	fdsu_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	assign in_stall = (state_q != S_IDLE) || ov_q;
	logic acc;
	assign acc = in_valid && !in_stall;

	logic [16:0]  need_u;
	logic [15:0]  alu;
	logic [15:0]  a;
	logic [15:0]  b;
	logic [31:0]  prod;
	logic         lt;
	logic [15:0]  shr;
	assign a = rd_q;
	assign b = tos_q;
	assign prod = a * b;
	assign lt = $signed(a) < $signed(b);
	assign shr = 16'($signed(a) >>> b[3:0]);
	assign need_u = {1'b0, tos_q} + 17'd2;

	always_comb begin
		case (cmd_q)
			CMD_ADD:    alu = a + b;
			CMD_SUB:    alu = a - b;
			CMD_MUL:    alu = prod[15:0];
			CMD_LSHIFT: alu = (b >= 16'd16) ? 16'd0 : 16'(a << b[3:0]);
			CMD_RSHIFT: alu = (b >= 16'd16) ? {16{a[15]}} : shr;
			CMD_AND:    alu = a & b;
			CMD_OR:     alu = a | b;
			CMD_XOR:    alu = a ^ b;
			CMD_EQ:     alu = (a == b) ? TRUE_CELL : 16'd0;
			CMD_NE:     alu = (a != b) ? TRUE_CELL : 16'd0;
			CMD_GT:     alu = (!lt && a != b) ? TRUE_CELL : 16'd0;
			CMD_GE:     alu = !lt ? TRUE_CELL : 16'd0;
			CMD_LT:     alu = lt ? TRUE_CELL : 16'd0;
			CMD_LE:     alu = (lt || a == b) ? TRUE_CELL : 16'd0;
			default:    alu = 16'd0;
		endcase
	end

	// Memory holds cells below the top; entry i is cell i, top lives in tos_q.
	always_comb begin
		we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
		dreq = '0;
		if (acc) begin
			re = 1'b1;
			raddr = AW'(cnt_q - CW'(2));
			if (command == CMD_PICK) raddr = AW'(cnt_q - CW'(2) - CW'(tos_q));
			if ((command == CMD_PUSH || command == CMD_DUP || command == CMD_OVER
				|| command == CMD_DEPTH) && cnt_q != 0 && cnt_q != FULL) begin
				we = 1'b1; waddr = AW'(cnt_q - CW'(1)); wdata = tos_q;
			end
		end
		case (state_q)
			S_RD2: begin
				re = 1'b1;
				raddr = AW'(cnt_q - CW'(2) - CW'(tos_q));
			end
			S_EXEC: begin
				if ((cmd_q == CMD_DIV || cmd_q == CMD_MOD) && tos_q != 0 && cnt_q >= CW'(2)) begin
					dreq.start = 1'b1; dreq.is_mod = (cmd_q == CMD_MOD);
					dreq.dividend = rd_q; dreq.divisor = tos_q;
				end
				if (cmd_q == CMD_SWAP && cnt_q >= CW'(2)) begin
					we = 1'b1; waddr = AW'(cnt_q - CW'(2)); wdata = tos_q;
				end
				if (cmd_q == CMD_ROLL) begin
					re = 1'b1; raddr = idx_q;
				end
			end
			S_RRD: begin
				re = 1'b1; raddr = AW'(idx_q + AW'(1));
			end
			S_RWR: begin
				we = 1'b1; waddr = idx_q; wdata = rd_q;
			end
			default: ;
		endcase
	end

	logic [1:0]    st_n;
	logic [CW-1:0] cnt_n;
	logic [15:0]   tos_n;
	logic [15:0]   pop_n;
	logic          pv_n;
	logic          fin;
	logic [2:0]    nxt;

	always_comb begin
		st_n = ST_OK; cnt_n = cnt_q; tos_n = tos_q; pop_n = '0; pv_n = 1'b0;
		fin = 1'b0; nxt = state_q;
		case (state_q)
			S_IDLE: if (acc) nxt = S_EXEC;
			S_RD2: nxt = S_RRD;
			S_EXEC: begin
				fin = 1'b1; nxt = S_IDLE;
				case (cmd_q)
					CMD_PUSH, CMD_DUP, CMD_OVER, CMD_DEPTH: begin
						if ((cmd_q == CMD_DUP && cnt_q < CW'(1))
							|| (cmd_q == CMD_OVER && cnt_q < CW'(2))) st_n = ST_UNDER;
						else if (cnt_q >= FULL) st_n = ST_OVER;
						else begin
							cnt_n = cnt_q + CW'(1);
							case (cmd_q)
								CMD_PUSH:  tos_n = lit_q;
								CMD_OVER:  tos_n = rd_q;
								CMD_DEPTH: tos_n = 16'(cnt_q);
								default:   tos_n = tos_q;
							endcase
						end
					end
					CMD_DROP, CMD_DOT: begin
						if (cnt_q < CW'(1)) st_n = ST_UNDER;
						else begin
							cnt_n = cnt_q - CW'(1); tos_n = rd_q;
							if (cmd_q == CMD_DOT) begin pop_n = tos_q; pv_n = 1'b1; end
						end
					end
					CMD_SWAP: begin
						if (cnt_q < CW'(2)) st_n = ST_UNDER;
						else tos_n = rd_q;
					end
					CMD_INVERT, CMD_NEGATE: begin
						if (cnt_q < CW'(1)) st_n = ST_UNDER;
						else tos_n = (cmd_q == CMD_INVERT) ? ~tos_q : 16'(-tos_q);
					end
					CMD_PICK, CMD_ROLL: begin
						if (cnt_q < CW'(1) || need_u > 17'(cnt_q)) st_n = ST_UNDER;
						else if (cmd_q == CMD_PICK) begin
							fin = 1'b0; nxt = S_DONE;
						end else if (tos_q == 16'd0) begin
							cnt_n = cnt_q - CW'(1); tos_n = rd_q;
						end else begin
							fin = 1'b0; nxt = S_RD2;
						end
					end
					CMD_DIV, CMD_MOD: begin
						if (cnt_q < CW'(2)) st_n = ST_UNDER;
						else if (tos_q == 16'd0) st_n = ST_DIVZ;
						else begin fin = 1'b0; nxt = S_DIV; end
					end
					default: begin
						if (cmd_q >= CMD_ADD && cmd_q <= CMD_LE) begin
							if (cnt_q < CW'(2)) st_n = ST_UNDER;
							else begin cnt_n = cnt_q - CW'(1); tos_n = alu; end
						end
					end
				endcase
			end
			S_DIV: if (drsp.done) begin
				fin = 1'b1; nxt = S_IDLE; cnt_n = cnt_q - CW'(1); tos_n = drsp.result;
			end
			S_RRD: nxt = S_RWR;
			S_RWR: begin
				if (idx_q == end_q) begin
					fin = 1'b1; nxt = S_IDLE; cnt_n = cnt_q - CW'(1); tos_n = saved_q;
				end else nxt = S_RRD;
			end
			S_DONE: begin
				fin = 1'b1; nxt = S_IDLE; tos_n = rd_q;
			end
			default: nxt = S_IDLE;
		endcase
		if (st_n != ST_OK) begin cnt_n = '0; tos_n = '0; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			tos_q   <= '0;
		end else begin
			state_q <= nxt;
			if (fin) begin
				cnt_q <= cnt_n;
				tos_q <= tos_n;
				ov_q  <= 1'b1;
			end else if (ov_q && !out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= command;
			lit_q <= literal;
		end
		if (state_q == S_EXEC) begin
			idx_q   <= AW'(cnt_q - CW'(2) - CW'(tos_q));
			end_q   <= AW'(cnt_q - CW'(3));
			first_q <= 1'b1;
		end
		if (state_q == S_RRD && first_q) begin
			saved_q <= rd_q;
			first_q <= 1'b0;
		end
		if (state_q == S_RWR) idx_q <= AW'(idx_q + AW'(1));
		if (fin) begin
			ost_q  <= st_n;
			otop_q <= (cnt_n == '0) ? 16'd0 : tos_n;
			odep_q <= 9'(cnt_n);
			opop_q <= pop_n;
			opv_q  <= pv_n;
		end
	end

	assign out_valid    = ov_q;
	assign status       = ost_q;
	assign top_value    = otop_q;
	assign stack_depth  = odep_q;
	assign popped_value = opop_q;
	assign popped_valid = opv_q;

`ifndef SYNTHESIS
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL) else $error("depth beyond capacity");
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> stack_depth == 9'd0) else $error("error kept cells");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accepted while busy");
`endif
endmodule
`default_nettype wire

FILE: tb/fdsu_checker.sv
// Checker: watches both channels of the data-stack unit, predicts each result and compares.
`timescale 1ns / 1ps
module fdsu_checker import fdsu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [4:0]  command,
	input  wire logic [15:0] literal,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  status,
	input  wire logic [15:0] top_value,
	input  wire logic [8:0]  stack_depth,
	input  wire logic [15:0] popped_value,
	input  wire logic        popped_valid,
	output int               fail_count,
	output int               pending
);
	localparam int DEPTH = 256;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] top;
		logic [8:0]  dep;
		logic [15:0] pv;
		logic        pvld;
	} stack_result_t;

	logic [15:0] cells [DEPTH];
	int unsigned cell_count;
	stack_result_t expected_results[$];

	function automatic logic [15:0] apply_binary(input logic [4:0] cmd, input logic [15:0] a,
			input logic [15:0] b);
		logic signed [15:0] sa;
		logic signed [15:0] sb;
		sa = a;
		sb = b;
		case (cmd)
			CMD_ADD: return a + b;
			CMD_SUB: return a - b;
			CMD_MUL: return a * b;
			CMD_DIV: return (sa == -16'sd32768 && sb == -16'sd1) ? a : 16'(sa / sb);
			CMD_MOD: return (sb == -16'sd1) ? 16'd0 : 16'(sa % sb);
			CMD_LSHIFT: return (b >= 16) ? 16'd0 : 16'(a << b[3:0]);
			CMD_RSHIFT: return (b >= 16) ? {16{a[15]}} : 16'(sa >>> b[3:0]);
			CMD_AND: return a & b;
			CMD_OR: return a | b;
			CMD_XOR: return a ^ b;
			CMD_EQ: return (sa == sb) ? TRUE_CELL : 16'd0;
			CMD_NE: return (sa != sb) ? TRUE_CELL : 16'd0;
			CMD_GT: return (sa > sb) ? TRUE_CELL : 16'd0;
			CMD_GE: return (sa >= sb) ? TRUE_CELL : 16'd0;
			CMD_LT: return (sa < sb) ? TRUE_CELL : 16'd0;
			default: return (sa <= sb) ? TRUE_CELL : 16'd0;
		endcase
	endfunction

	function automatic stack_result_t execute_command(input logic [4:0] cmd,
			input logic [15:0] lit);
		stack_result_t r;
		int unsigned c;
		int unsigned u;
		int unsigned idx;
		logic [15:0] saved;
		r = '0;
		r.st = ST_OK;
		c = cell_count;
		case (cmd)
			CMD_PUSH, CMD_DUP, CMD_OVER, CMD_DEPTH: begin
				if ((cmd == CMD_DUP && c < 1) || (cmd == CMD_OVER && c < 2))
					r.st = ST_UNDER;
				else if (c >= DEPTH)
					r.st = ST_OVER;
				else begin
					case (cmd)
						CMD_PUSH: cells[c] = lit;
						CMD_DUP: cells[c] = cells[c - 1];
						CMD_OVER: cells[c] = cells[c - 2];
						default: cells[c] = 16'(c);
					endcase
					c++;
				end
			end
			CMD_DROP, CMD_DOT: begin
				if (c < 1)
					r.st = ST_UNDER;
				else begin
					c--;
					if (cmd == CMD_DOT) begin
						r.pv = cells[c];
						r.pvld = 1'b1;
					end
				end
			end
			CMD_SWAP: begin
				if (c < 2)
					r.st = ST_UNDER;
				else begin
					saved = cells[c - 2];
					cells[c - 2] = cells[c - 1];
					cells[c - 1] = saved;
				end
			end
			CMD_INVERT, CMD_NEGATE: begin
				if (c < 1)
					r.st = ST_UNDER;
				else
					cells[c - 1] = (cmd == CMD_INVERT) ? ~cells[c - 1] : -cells[c - 1];
			end
			CMD_PICK, CMD_ROLL: begin
				u = (c >= 1) ? cells[c - 1] : 0;
				if (c < 1 || u + 2 > c)
					r.st = ST_UNDER;
				else if (cmd == CMD_PICK)
					cells[c - 1] = cells[c - 2 - u];
				else begin
					c--;
					idx = c - 1 - u;
					saved = cells[idx];
					for (int i = 0; i < u; i++)
						cells[idx + i] = cells[idx + i + 1];
					cells[c - 1] = saved;
				end
			end
			default: begin
				if (cmd >= CMD_ADD && cmd <= CMD_LE) begin
					if (c < 2)
						r.st = ST_UNDER;
					else if ((cmd == CMD_DIV || cmd == CMD_MOD) && cells[c - 1] == 0)
						r.st = ST_DIVZ;
					else begin
						cells[c - 2] = apply_binary(cmd, cells[c - 2], cells[c - 1]);
						c--;
					end
				end
			end
		endcase
		if (r.st != ST_OK)
			c = 0;
		cell_count = c;
		r.top = (c != 0) ? cells[c - 1] : 16'd0;
		r.dep = 9'(c);
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		stack_result_t exp_r;
		stack_result_t act_r;
		if (!arst_n) begin
			cell_count = 0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(execute_command(command, literal));
			if (out_valid && !out_stall) begin
				act_r = '{status, top_value, stack_depth, popped_value, popped_valid};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transaction %p", act_r);
				end else begin
					exp_r = expected_results.pop_front();
					if (act_r !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p actual %p", exp_r, act_r);
					end
				end
			end
		end
	end
endmodule

FILE: tb/testbench.sv
// Testbench top: drives commands into the data-stack unit and reports the verdict.
`timescale 1ns / 1ps
module testbench import fdsu_pkg::*;;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [4:0]  command;
	logic [15:0] literal;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [15:0] top_value;
	logic [8:0]  stack_depth;
	logic [15:0] popped_value;
	logic        popped_valid;
	int          fail_count;
	int          pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          model_depth;

	forth_data_stack_unit u_dut (.*);

	fdsu_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Some tests failed");
		$finish;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic send_command(input logic [4:0] cmd, input logic [15:0] lit);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			command <= 5'($urandom);
			literal <= 16'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		literal <= lit;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic push_value(input logic [15:0] v);
		send_command(CMD_PUSH, v);
		model_depth = (model_depth >= 256) ? 0 : model_depth + 1;
	endtask

	task automatic random_command();
		logic [4:0] cmd;
		int unsigned sel;
		sel = $urandom_range(99);
		if (model_depth < 2 || sel < 30) begin
			case ($urandom_range(3))
				0: push_value(16'($urandom_range(6)));
				1: push_value(16'hFFFF - 16'($urandom_range(2)));
				2: push_value({1'b1, 15'($urandom)});
				default: push_value(16'($urandom));
			endcase
			return;
		end
		if (sel < 40 && model_depth > 2)
			push_value(16'($urandom_range(model_depth - 2)));
		cmd = 5'($urandom_range(31));
		if (cmd == CMD_ROLL || cmd == CMD_PICK)
			model_depth = (model_depth >= 2) ? model_depth - (cmd == CMD_ROLL) : 0;
		else if (cmd == CMD_DROP || cmd == CMD_DOT || (cmd >= CMD_ADD && cmd <= CMD_LE))
			model_depth = (model_depth > 0) ? model_depth - 1 : 0;
		else if (cmd == CMD_DUP || cmd == CMD_OVER || cmd == CMD_DEPTH)
			model_depth = model_depth + 1;
		if (cmd == CMD_DIV || cmd == CMD_MOD || cmd == CMD_ROLL || cmd == CMD_PICK)
			model_depth = 0;
		send_command(cmd, 16'($urandom));
	endtask

	initial begin
		int cycles;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_PUSH;
		literal = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		model_depth = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_command(CMD_DROP, 16'h0);
		send_command(CMD_DUP, 16'h0);
		send_command(CMD_PICK, 16'h0);
		send_command(CMD_DEPTH, 16'h0);
		send_command(CMD_PUSH, 16'h7FFF);
		send_command(CMD_PUSH, 16'h8000);
		send_command(CMD_DIV, 16'h0);
		send_command(CMD_PUSH, 16'h8000);
		send_command(CMD_PUSH, 16'hFFFF);
		send_command(CMD_OVER, 16'h0);
		send_command(CMD_OVER, 16'h0);
		send_command(CMD_MOD, 16'h0);
		send_command(CMD_SWAP, 16'h0);
		send_command(CMD_DIV, 16'h0);
		send_command(CMD_PUSH, 16'h0);
		send_command(CMD_MOD, 16'h0);
		for (int i = 0; i < 256; i++)
			send_command(CMD_PUSH, 16'(i));
		send_command(CMD_PUSH, 16'h1234);
		send_command(CMD_PUSH, 16'h5);
		send_command(CMD_PUSH, 16'h6);
		send_command(CMD_PUSH, 16'h7);
		send_command(CMD_PUSH, 16'h2);
		send_command(CMD_ROLL, 16'h0);
		send_command(CMD_PUSH, 16'h0);
		send_command(CMD_ROLL, 16'h0);
		send_command(CMD_PUSH, 16'h2);
		send_command(CMD_PICK, 16'h0);
		send_command(CMD_PUSH, 16'hFFF0);
		send_command(CMD_RSHIFT, 16'h0);
		send_command(CMD_PUSH, 16'h10);
		send_command(CMD_LSHIFT, 16'h0);
		send_command(CMD_PUSH, 16'h5);
		send_command(CMD_ROLL, 16'h0);
		send_command(CMD_NEGATE, 16'h0);
		send_command(CMD_INVERT, 16'h0);
		send_command(CMD_DOT, 16'h0);
		send_command(5'd31, 16'hFFFF);
		model_depth = 0;

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 53 : 0;
			recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 37 : 0;
			for (int i = 0; i < 80; i++)
				random_command();
			send_command(CMD_DROP, 16'h0);
			while (model_depth < 255 && phase == 1)
				push_value(16'($urandom));
			if (phase == 1) begin
				send_command(CMD_DEPTH, 16'h0);
				send_command(CMD_OVER, 16'h0);
				model_depth = 0;
			end
		end
		in_valid <= 1'b0;

		cycles = 0;
		while (pending != 0 && cycles < 100000) begin
			@(posedge clk);
			cycles++;
		end
		repeat (600) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/fdsu_pkg.sv
hw/rtl/fdsu_div.sv
hw/rtl/forth_data_stack_unit.sv
tb/fdsu_checker.sv
tb/testbench.sv
